[hdl/pattern_interval_timer_core_assert.svh]
// Assertion macros shared by the timer core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PATTERN_INTERVAL_TIMER_CORE_ASSERT_SVH
`define PATTERN_INTERVAL_TIMER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pit_pkg.sv]
package pit_pkg;

  localparam int TIME_W            = 32;
  localparam int ACTION_W          = 3;
  localparam int MODE_W            = 2;
  localparam int PLEN_W            = 3;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int PATTERN_DEPTH_DEF = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD0    = 3'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK         = 3'd0,
    ACT_POLL_STORED  = 3'd1,
    ACT_POLL_GIVEN   = 3'd2,
    ACT_POLL_PATTERN = 3'd3,
    ACT_CLEAR        = 3'd4
  } pit_action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRIGGER  = 2'd0,
    MODE_SWITCH   = 2'd1,
    MODE_DISABLED = 2'd2
  } pit_mode_t;

  // Decisions taken by the execute logic for one request.
  typedef struct packed {
    logic has_result;
    logic result;
    logic elapsed_clr;
    logic elapsed_inc;
    logic flag_tog;
    logic step_adv;
  } pit_ctrl_t;

  // Width of the pattern step counter for a given table depth.
  function automatic int pit_step_w(input int depth);
    pit_step_w = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

[hdl/pit_cfg_regs.sv]
module pit_cfg_regs #(
  parameter int PATTERN_DEPTH = pit_pkg::PATTERN_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pit_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pit_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [pit_pkg::TIME_W-1:0]      cooldown,
  output logic [pit_pkg::MODE_W-1:0]      mode,
  output logic [pit_pkg::PLEN_W-1:0]      plen,
  output logic [pit_pkg::TIME_W-1:0]      words [PATTERN_DEPTH]
);
  import pit_pkg::*;

  logic [TIME_W-1:0] cooldown_r;
  logic [MODE_W-1:0] mode_r;
  logic [PLEN_W-1:0] plen_r;
  logic [TIME_W-1:0] words_r [PATTERN_DEPTH];

  // Pattern words beyond the table depth are never read, so they are not kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooldown_r <= '0;
      mode_r     <= '0;
      plen_r     <= '0;
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
        words_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_COOLDOWN) cooldown_r <= cfg_wdata[TIME_W-1:0];
      if (cfg_index == CFG_MODE)     mode_r     <= cfg_wdata[MODE_W-1:0];
      if (cfg_index == CFG_PLEN)     plen_r     <= cfg_wdata[PLEN_W-1:0];
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
        if (cfg_index == CFG_IDX_W'(int'(CFG_WORD0) + i)) begin
          words_r[i] <= cfg_wdata[TIME_W-1:0];
        end
      end
    end
  end

  assign cooldown = cooldown_r;
  assign mode     = mode_r;
  assign plen     = plen_r;
  assign words    = words_r;

endmodule

[hdl/pit_exec.sv]
module pit_exec #(
  parameter int PATTERN_DEPTH = pit_pkg::PATTERN_DEPTH_DEF,
  parameter int STEP_W        = pit_pkg::pit_step_w(PATTERN_DEPTH)
) (
  input  logic [pit_pkg::ACTION_W-1:0] action,
  input  logic [pit_pkg::TIME_W-1:0]   given,
  input  logic [pit_pkg::TIME_W-1:0]   cooldown,
  input  logic [pit_pkg::MODE_W-1:0]   mode,
  input  logic [pit_pkg::PLEN_W-1:0]   plen,
  input  logic [pit_pkg::TIME_W-1:0]   words [PATTERN_DEPTH],
  input  logic [pit_pkg::TIME_W-1:0]   elapsed,
  input  logic [STEP_W-1:0]            step,
  input  logic                         flag,
  output pit_pkg::pit_ctrl_t           ctrl,
  output logic [STEP_W-1:0]            step_nxt
);
  import pit_pkg::*;

  localparam logic [PLEN_W-1:0] DEPTH_L = PLEN_W'(PATTERN_DEPTH);

  pit_action_t       act;
  logic [PLEN_W-1:0] len;
  logic [STEP_W-1:0] cur;
  logic [PLEN_W-1:0] cur_inc;
  logic [TIME_W-1:0] word_sel;
  logic [TIME_W-1:0] limit;
  logic              expired;
  logic              pat;
  logic              empty;

  assign act = pit_action_t'(action);

  // Length in use saturates at the table depth; an out-of-range step reads word 0.
  assign len = (plen > DEPTH_L) ? DEPTH_L : plen;
  assign cur = (PLEN_W'(step) < len) ? step : '0;

  always_comb begin
    word_sel = words[0];
    for (int i = 1; i < PATTERN_DEPTH; i++) begin
      if (cur == STEP_W'(i)) word_sel = words[i];
    end
  end

  assign pat     = (act == ACT_POLL_PATTERN);
  assign empty   = pat && (len == '0);
  assign limit   = (act == ACT_POLL_STORED) ? cooldown :
                   (act == ACT_POLL_GIVEN)  ? given    : word_sel;
  assign expired = (elapsed >= limit);

  assign cur_inc  = PLEN_W'(cur) + PLEN_W'(1);
  assign step_nxt = (cur_inc >= len) ? '0 : cur_inc[STEP_W-1:0];

  always_comb begin
    ctrl = '0;
    case (act)
      ACT_TICK:  ctrl.elapsed_inc = 1'b1;
      ACT_CLEAR: ctrl.elapsed_clr = 1'b1;
      ACT_POLL_STORED, ACT_POLL_GIVEN, ACT_POLL_PATTERN: begin
        ctrl.has_result = 1'b1;
        if (!empty) begin
          if (mode == MODE_TRIGGER) begin
            ctrl.result      = expired;
            ctrl.elapsed_clr = expired;
            ctrl.step_adv    = expired && pat;
          end else if (mode == MODE_SWITCH) begin
            // The step moves on only when the flag falls back to off.
            ctrl.result      = flag ^ expired;
            ctrl.flag_tog    = expired;
            ctrl.elapsed_clr = expired;
            ctrl.step_adv    = expired && pat && flag;
          end
        end
      end
      default: ctrl = '0;
    endcase
  end

endmodule

[hdl/pattern_interval_timer_core.sv]
// Path: a request is captured in the input register and its result in the output register.
// Throughput: one request per cycle while the output is not stalled; the execute stage
// closes the state loop (counter, flag and pattern step) combinationally, and the output register
// lets a new request in while a result waits.
// Reset: synchronous, active low; clears all configuration, the counter,
// the step, the flag and both stage valids.
`include "pattern_interval_timer_core_assert.svh"

module pattern_interval_timer_core #(
  parameter int PATTERN_DEPTH = pit_pkg::PATTERN_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pit_pkg::ACTION_W-1:0]   in_action,
  input  logic [pit_pkg::TIME_W-1:0]     in_cooldown_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_timer_state,
  input  logic                           cfg_we,
  input  logic [pit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pit_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pit_pkg::*;

  localparam int STEP_W = pit_step_w(PATTERN_DEPTH);

  // Configuration registers.
  logic [TIME_W-1:0] cfg_cooldown;
  logic [MODE_W-1:0] cfg_mode;
  logic [PLEN_W-1:0] cfg_plen;
  logic [TIME_W-1:0] cfg_words [PATTERN_DEPTH];

  // Input register: holds one request for the execute stage.
  logic                s1_valid_r, s1_valid_nxt;
  logic [ACTION_W-1:0] s1_action_r;
  logic [TIME_W-1:0]   s1_given_r;

  // Timer state.
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              flag_r, flag_nxt;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  logic out_state_r, out_state_nxt;

  pit_ctrl_t         ctrl;
  logic [STEP_W-1:0] step_adv_val;
  logic              out_free;
  logic              s1_adv;
  logic              in_take;

  pit_cfg_regs #(
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cooldown  (cfg_cooldown),
    .mode      (cfg_mode),
    .plen      (cfg_plen),
    .words     (cfg_words)
  );

  pit_exec #(
    .PATTERN_DEPTH (PATTERN_DEPTH),
    .STEP_W        (STEP_W)
  ) u_exec (
    .action   (s1_action_r),
    .given    (s1_given_r),
    .cooldown (cfg_cooldown),
    .mode     (cfg_mode),
    .plen     (cfg_plen),
    .words    (cfg_words),
    .elapsed  (elapsed_r),
    .step     (step_r),
    .flag     (flag_r),
    .ctrl     (ctrl),
    .step_nxt (step_adv_val)
  );

  // The execute stage retires its request when that request gives no result,
  // or when the output register is empty or being emptied this cycle. A tick
  // or clear therefore never waits on the result side.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!ctrl.has_result || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  // State only moves when the execute stage retires its request, so a stalled
  // poll is evaluated again, unchanged, in the following cycle.
  always_comb begin
    elapsed_nxt = elapsed_r;
    step_nxt    = step_r;
    flag_nxt    = flag_r;
    if (s1_adv) begin
      if (ctrl.elapsed_clr) begin
        elapsed_nxt = '0;
      end else if (ctrl.elapsed_inc) begin
        elapsed_nxt = elapsed_r + TIME_W'(1);
      end
      if (ctrl.step_adv) step_nxt = step_adv_val;
      if (ctrl.flag_tog) flag_nxt = !flag_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_state_nxt = out_state_r;
    if (s1_adv && ctrl.has_result) begin
      out_valid_nxt = 1'b1;
      out_state_nxt = ctrl.result;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      elapsed_r   <= '0;
      step_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      elapsed_r   <= elapsed_nxt;
      step_r      <= step_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_action;
      s1_given_r  <= in_cooldown_value;
    end
    out_state_r <= out_state_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_timer_state = out_state_r;

  // The input side is only held back by a request sitting in the execute stage.
  `PIT_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_r, "stall without a held request")
  // A retired tick moves the counter on by exactly one.
  `PIT_ASSERT_NEXT(a_tick_counts, s1_adv && ctrl.elapsed_inc,
                   elapsed_r == $past(elapsed_r) + TIME_W'(1), "tick did not advance counter")
  // With the timer disabled a poll reports zero.
  `PIT_ASSERT_NEXT(a_disabled_zero,
                   s1_adv && ctrl.has_result && (cfg_mode == MODE_DISABLED),
                   out_valid && !out_timer_state, "disabled poll did not report zero")

endmodule

[verif/pattern_interval_timer_core_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the polled interval timer core.
// Requests are driven on the input channel and every result is compared with the
// prediction of a small behavioural timer kept inside this module.
module pattern_interval_timer_core_tb;
  import pit_pkg::*;

  localparam int TB_DEPTH = PATTERN_DEPTH_DEF;

  // Codes that the package does not name: a mode the core does not know and the
  // three reserved actions, which the core must swallow without a result.
  localparam logic [MODE_W-1:0]   MODE_UNKNOWN     = 2'd3;
  localparam logic [ACTION_W-1:0] ACT_RESERVED_LO  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RESERVED_MID = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RESERVED_HI  = 3'd7;

  // Cycles without any accepted request, result or register write before the run
  // is declared hung. The longest legitimate quiet spell is the long receiver
  // hold-off (LONG_HOLD) plus a long sender gap, so this leaves ample margin.
  localparam int HANG_LIMIT = 3000;
  localparam int LONG_HOLD  = 300;
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 228;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [ACTION_W-1:0]   in_action;
  logic [TIME_W-1:0]     in_cooldown_value;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_timer_state;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pattern_interval_timer_core #(
    .PATTERN_DEPTH(TB_DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_cooldown_value(in_cooldown_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_timer_state  (out_timer_state),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #1 clk = ~clk;

  // One line of the directed table: either a register write or a request. Where the
  // outcome of a poll is obvious, it is typed in and takes the place of the prediction.
  typedef struct packed {
    logic                  is_reg;
    logic [ACTION_W-1:0]   code;
    logic [TIME_W-1:0]     data;
    logic                  typed;
    logic                  want;
  } row_t;

  // Behavioural copy of the configuration registers.
  logic [TIME_W-1:0] reg_cooldown;
  logic [MODE_W-1:0] reg_mode;
  logic [PLEN_W-1:0] reg_plen;
  logic [TIME_W-1:0] reg_words [4];

  // Behavioural copy of the timer state.
  logic [TIME_W-1:0] pred_elapsed;
  logic [1:0]        pred_step;
  logic              pred_flag;

  // Timer states still owed by the core, oldest first.
  logic pending_states [$];

  // Run statistics and control shared between the processes.
  int  fail_count   = 0;
  int  n_sent       = 0;
  int  n_ignored    = 0;
  int  n_results    = 0;
  int  n_expired    = 0;
  int  n_writes     = 0;
  int  idle_cycles  = 0;
  bit  idle_on      = 1'b1;
  bit  long_hold_req = 1'b0;

  logic [MODE_W-1:0] phase_modes [PHASES] = '{MODE_TRIGGER, MODE_SWITCH, MODE_TRIGGER,
    MODE_SWITCH, MODE_DISABLED, MODE_TRIGGER, MODE_SWITCH, MODE_UNKNOWN};

  // Pause length shared by the sender gaps and the receiver stalls: mostly none or
  // short, now and then a long one.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Interval values: small ones so that expiry happens often, with both extremes
  // and now and then a full-width random word.
  function automatic logic [TIME_W-1:0] pick_interval();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return $urandom;
    return $urandom_range(0, 12);
  endfunction

  // Mirror of one register write.
  function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_COOLDOWN) reg_cooldown = val;
    else if (idx == CFG_MODE) reg_mode = val[MODE_W-1:0];
    else if (idx == CFG_PLEN) reg_plen = val[PLEN_W-1:0];
    else if (idx >= CFG_WORD0 && int'(idx) < int'(CFG_WORD0) + 4)
      reg_words[int'(idx) - int'(CFG_WORD0)] = val;
  endfunction

  // Works out what one accepted request does to the timer and whether it owes a
  // result. Ticks, clears and reserved actions never produce one.
  function automatic void advance_timer(input logic [ACTION_W-1:0] act,
                                        input logic [TIME_W-1:0] given,
                                        output bit has, output bit state);
    logic [TIME_W-1:0] limit;
    int  len;
    int  cur;
    bit  pat;
    bit  hit;
    has   = 1'b0;
    state = 1'b0;
    pat   = 1'b0;
    len   = 0;
    cur   = 0;
    if (act == ACT_TICK) begin
      pred_elapsed = pred_elapsed + 1'b1;
      return;
    end
    if (act == ACT_CLEAR) begin
      pred_elapsed = '0;
      return;
    end
    if (act > ACT_CLEAR) return;
    has = 1'b1;
    if (act == ACT_POLL_STORED) begin
      limit = reg_cooldown;
    end else if (act == ACT_POLL_GIVEN) begin
      limit = given;
    end else begin
      pat = 1'b1;
      len = (int'(reg_plen) > TB_DEPTH) ? TB_DEPTH : int'(reg_plen);
      // An empty pattern answers zero and leaves everything alone.
      if (len == 0) return;
      // A step left beyond a shortened pattern falls back to the first word.
      cur   = (int'(pred_step) < len) ? int'(pred_step) : 0;
      limit = reg_words[cur];
    end
    // Disabled and unknown modes answer zero without touching the state.
    if (reg_mode != MODE_TRIGGER && reg_mode != MODE_SWITCH) return;
    hit = (pred_elapsed >= limit);
    if (reg_mode == MODE_TRIGGER) begin
      if (hit) begin
        pred_elapsed = '0;
        if (pat) pred_step = (cur + 1 >= len) ? 2'd0 : 2'(cur + 1);
      end
      state = hit;
      return;
    end
    if (hit) begin
      pred_flag    = ~pred_flag;
      pred_elapsed = '0;
      // In switch mode the pattern moves on only once the flag is back to off.
      if (pat && !pred_flag) pred_step = (cur + 1 >= len) ? 2'd0 : 2'(cur + 1);
    end
    state = pred_flag;
  endfunction

  // Offers one request and holds it until the core takes it, then records what the
  // core owes for it. A typed expectation, where given, replaces the prediction.
  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [TIME_W-1:0] val,
                              input bit typed, input bit want);
    int gap;
    bit has;
    bit state;
    gap = (idle_on && !long_hold_req) ? pick_pause() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= act;
    in_cooldown_value <= val;
    do @(posedge clk); while (in_stall);
    advance_timer(act, val, has, state);
    if (has) pending_states.push_back(typed ? want : state);
    if (act > ACT_CLEAR) n_ignored++;
    n_sent++;
    // Switch sender idling on and off in stretches so that bursts happen too.
    if (n_sent % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
  endtask

  // Waits until every owed result has come back, then lets a tick or clear still
  // in the pipeline settle before the registers change.
  task automatic wait_drained();
    while (pending_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the enable is left high so that writes can follow back to
  // back, and the caller lowers it once the batch is done.
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    store_setting(idx, val);
    n_writes++;
  endtask

  // Receiver: stalls of random length, mostly brief, with stall-free stretches, and
  // once on request a long hold-off so that the core fills up and stalls its input.
  initial begin : receiver
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = long_hold_req ? LONG_HOLD : pick_pause();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        if (hold == LONG_HOLD) long_hold_req = 1'b0;
      end
      out_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  // Compares each accepted result with the oldest owed timer state.
  always @(posedge clk) begin : result_check
    logic want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_timer_state) n_expired++;
      if (pending_states.size() == 0) begin
        $display("%0t: unexpected result, nothing expected, got timer_state=%0b",
                 $time, out_timer_state);
        fail_count++;
      end else begin
        want = pending_states.pop_front();
        if (out_timer_state !== want) begin
          $display("%0t: timer_state mismatch, expected %0b, got %0b",
                   $time, want, out_timer_state);
          fail_count++;
        end
      end
    end
  end

  // Hang detection: the run ends if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results still owed",
               $time, HANG_LIMIT, pending_states.size());
      $display("FAIL pattern_interval_timer_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t plan [$];
    row_t row;
    bit   writing;
    bit   hold_issued;
    bit   pause_issued;
    int   done;
    int   ticks;
    int   r;
    in_valid          = 1'b0;
    in_action         = ACT_TICK;
    in_cooldown_value = '0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_COOLDOWN;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    reg_cooldown      = '0;
    reg_mode          = MODE_TRIGGER;
    reg_plen          = '0;
    foreach (reg_words[i]) reg_words[i] = '0;
    pred_elapsed      = '0;
    pred_step         = '0;
    pred_flag         = 1'b0;
    writing           = 1'b0;
    hold_issued       = 1'b0;
    pause_issued      = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Straight after reset everything is zero in trigger mode, so a
    // stored-cooldown poll expires at once and a poll against the largest interval
    // cannot. The pattern is empty until its length is written.
    plan.push_back('{1'b0, ACT_POLL_STORED, 32'h0000_0000, 1'b1, 1'b1});
    plan.push_back('{1'b0, ACT_POLL_GIVEN, 32'hFFFF_FFFF, 1'b1, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_PATTERN, 32'hFFFF_FFFF, 1'b1, 1'b0});
    plan.push_back('{1'b0, ACT_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_TICK, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_GIVEN, 32'h0000_0002, 1'b1, 1'b1});
    // Reserved actions are swallowed without a result.
    plan.push_back('{1'b0, ACT_RESERVED_LO, 32'hFFFF_FFFF, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_RESERVED_MID, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_RESERVED_HI, 32'h5555_5555, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_TICK, 32'hAAAA_AAAA, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_CLEAR, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_GIVEN, 32'h0000_0001, 1'b1, 1'b0});
    // Disabled and unknown modes answer zero even where expiry would be due.
    plan.push_back('{1'b1, CFG_MODE, 32'(MODE_DISABLED), 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_STORED, 32'h0000_0000, 1'b1, 1'b0});
    plan.push_back('{1'b1, CFG_MODE, 32'(MODE_UNKNOWN), 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_GIVEN, 32'h0000_0000, 1'b1, 1'b0});
    // A full pattern of zero intervals in trigger mode walks the step to the last
    // word; shrinking the length then leaves the step beyond it, and the next poll
    // falls back to the first word before the step wraps round.
    plan.push_back('{1'b1, CFG_MODE, 32'(MODE_TRIGGER), 1'b0, 1'b0});
    plan.push_back('{1'b1, CFG_PLEN, 32'd4, 1'b0, 1'b0});
    plan.push_back('{1'b1, CFG_WORD0, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b1, CFG_WORD0 + 3'd1, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b1, CFG_WORD0 + 3'd2, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b1, CFG_WORD0 + 3'd3, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b1, CFG_COOLDOWN, 32'hFFFF_FFFF, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_PATTERN, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_PATTERN, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_PATTERN, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b1, CFG_PLEN, 32'd2, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_PATTERN, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_PATTERN, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_STORED, 32'h0000_0000, 1'b1, 1'b0});
    // Switch mode with an oversized length, which saturates at the table depth.
    plan.push_back('{1'b1, CFG_MODE, 32'(MODE_SWITCH), 1'b0, 1'b0});
    plan.push_back('{1'b1, CFG_PLEN, 32'd7, 1'b0, 1'b0});
    plan.push_back('{1'b1, CFG_WORD0 + 3'd1, 32'hFFFF_FFFF, 1'b0, 1'b0});
    plan.push_back('{1'b1, CFG_WORD0 + 3'd3, 32'h0000_0003, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_PATTERN, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_PATTERN, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_GIVEN, 32'h0000_0000, 1'b0, 1'b0});
    plan.push_back('{1'b0, ACT_POLL_STORED, 32'h0000_0000, 1'b0, 1'b0});

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_reg) begin
        // Registers only change once the core has gone quiet.
        if (!writing) begin
          in_valid <= 1'b0;
          wait_drained();
          writing = 1'b1;
        end
        write_setting(row.code, row.data);
      end else begin
        if (writing) begin
          cfg_we  <= 1'b0;
          writing = 1'b0;
        end
        send_request(row.code, row.data, row.typed, row.want);
      end
    end

    // Random phases, each under its own settings. Most of the traffic is runs of
    // ticks closed by a poll, so that intervals really do expire; clears and
    // reserved actions are sprinkled in as noise.
    for (int phase = 0; phase < PHASES; phase++) begin
      in_valid <= 1'b0;
      wait_drained();
      write_setting(CFG_COOLDOWN, (phase == 0) ? 32'h0 :
                                  (phase == 2) ? 32'hFFFF_FFFF : pick_interval());
      write_setting(CFG_MODE, 32'(phase_modes[phase]));
      r = $urandom_range(0, 9);
      write_setting(CFG_PLEN, (phase == 1) ? 32'd0 : (phase == 6) ? 32'd7 :
                              (r == 0) ? 32'($urandom_range(5, 7)) :
                              32'($urandom_range(1, 4)));
      for (int w = 0; w < 4; w++)
        write_setting(CFG_WORD0 + 3'(w), (phase == 2) ? 32'hFFFF_FFFF : pick_interval());
      cfg_we <= 1'b0;

      done = 0;
      while (done < PHASE_ITEMS) begin
        // Once, a long receiver hold-off while requests keep coming at full rate.
        if (phase == 3 && done >= 60 && !hold_issued) begin
          long_hold_req = 1'b1;
          hold_issued   = 1'b1;
        end
        // Once, the sender stops until every owed result is back.
        if (phase == 5 && done >= 100 && !pause_issued) begin
          in_valid <= 1'b0;
          wait_drained();
          pause_issued = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 6) begin
          send_request(3'($urandom_range(5, 7)), $urandom, 1'b0, 1'b0);
        end else if (r < 10) begin
          send_request(ACT_CLEAR, $urandom, 1'b0, 1'b0);
          done++;
        end else begin
          ticks = $urandom_range(0, 10);
          repeat (ticks) send_request(ACT_TICK, $urandom, 1'b0, 1'b0);
          done += ticks;
          send_request(3'($urandom_range(1, 3)),
                       ($urandom_range(0, 4) == 0) ? 32'($urandom) : pick_interval(),
                       1'b0, 1'b0);
          done++;
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d requests (%0d reserved), checked %0d results (%0d set).",
             n_sent, n_ignored, n_results, n_expired);
    $display("Made %0d register writes across the directed table and %0d random phases.",
             n_writes, PHASES);
    if (fail_count == 0) begin
      $display("PASS pattern_interval_timer_core");
    end else begin
      $display("%0d failures", fail_count);
      $display("FAIL pattern_interval_timer_core");
    end
    $finish;
  end

endmodule
